### hw/rtl/ustq_pkg.sv
// ----------------------------------------------------------------------------
// ustq_pkg
// Shared types and codes for the urgency-sorted ticket queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ustq_pkg;

    localparam int MAX_SLOTS_DEF = 16;
    localparam int CFG_W         = 5;
    localparam int TICKET_W      = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd10;

    // op codes
    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_SORT = 2'd1;
    localparam logic [1:0] OP_DEQ  = 2'd2;

    // status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    typedef struct packed {
        logic [2:0]  urgency;
        logic [7:0]  age;
        logic [1:0]  sex;
        logic [1:0]  insurance;
        logic [15:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

### hw/rtl/ustq_slot_ram.sv
// ----------------------------------------------------------------------------
// ustq_slot_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ustq_slot_ram #(
    parameter int DEPTH = ustq_pkg::MAX_SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire ustq_pkg::t_entry       i_wdata,
    input  wire logic [AW-1:0]          i_raddr,
    output ustq_pkg::t_entry            o_rdata
);
    import ustq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/urgency_sorted_ticket_queue_unit.sv
// ----------------------------------------------------------------------------
// urgency_sorted_ticket_queue_unit
// Slot-array ticket queue with enqueue, dequeue and in-place urgency sort.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive an op and its fields with start high; the beat is
//   taken when start is high and busy is low. Op 0 enqueues at the tail, op 1
//   sorts the live slots [head, tail) by descending urgency, op 2 dequeues
//   the head. Op 3 is taken and dropped without a result.
//   Result channel: one beat per op 0 to 2, shown on the o_ ports for one cycle
//   with o_strobe high. There is no back-pressure; the receiver must take it.
//   Config: i_cfg_we writes capacity_limit; write only while busy is low.
// Timing:
//   Enqueue, full, empty and trivial sort: result in the cycle after accept;
//   busy never rises, so a new beat can be taken every cycle.
//   Dequeue: the head slot comes through the registered RAM port into S_DEQ,
//   which registers the result. Sort: the single compare/exchange path walks
//   the RAM one slot per cycle in S_SORT_J, between S_SORT_LD_I and S_SORT_WB_I.
//   busy is high throughout the sort.
// Reset:
//   Synchronous, active low. Head and tail return to 0, capacity to 10.
//   Slot contents are not cleared; only data from written slots is ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module urgency_sorted_ticket_queue_unit #(
    parameter int MAX_SLOTS = ustq_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command beat
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_op,
    input  wire logic [2:0]                    i_urgency,
    input  wire logic [7:0]                    i_age,
    input  wire logic [1:0]                    i_sex,
    input  wire logic [1:0]                    i_insurance,
    input  wire logic [15:0]                   i_tag,
    // config
    input  wire logic                          i_cfg_we,
    input  wire logic [ustq_pkg::CFG_W-1:0]    i_cfg_wdata,
    // result beat
    output logic                               o_strobe,
    output logic [1:0]                         o_status,
    output logic [ustq_pkg::TICKET_W-1:0]      o_ticket,
    output logic [2:0]                         o_out_urgency,
    output logic [7:0]                         o_out_age,
    output logic [1:0]                         o_out_sex,
    output logic [1:0]                         o_out_insurance,
    output logic [15:0]                        o_out_tag
);
    import ustq_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);        // slot index
    localparam int CW = $clog2(MAX_SLOTS + 1);    // head/tail, can reach MAX_SLOTS
    localparam int XW = (CW > CFG_W) ? CW : CFG_W; // compare/ticket width

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT_RD_I,
        S_SORT_LD_I,
        S_SORT_J,
        S_SORT_WB_I,
        S_DEQ
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    t_entry              r_ei, n_ei;        // running winner for slot i
    logic [CFG_W-1:0]    r_cap;
    logic                r_strobe, n_strobe;
    logic [1:0]          r_status, n_status;
    logic [TICKET_W-1:0] r_ticket, n_ticket;
    t_entry              r_out, n_out;

    // RAM port
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic [IW-1:0]       ram_raddr;
    t_entry              ram_rdata;

    t_entry              in_entry;
    logic                full;
    logic                few;               // fewer than two live entries
    logic                empty;
    logic [XW-1:0]       tail_inc;
    logic [XW-1:0]       head_inc;
    logic [CW-1:0]       j_inc;
    logic                j_more;
    logic                i_more;

    assign in_entry = '{urgency: i_urgency, age: i_age, sex: i_sex,
                        insurance: i_insurance, tag: i_tag};

    // full once tail reaches min(capacity, MAX_SLOTS)
    assign full  = (XW'(r_tail) >= XW'(r_cap)) || (r_tail >= CW'(MAX_SLOTS));
    assign empty = (r_head >= r_tail) || (r_head >= CW'(MAX_SLOTS));
    assign few   = ({1'b0, r_head} + (CW+1)'(1)) >= {1'b0, r_tail};

    assign tail_inc = XW'(r_tail) + XW'(1);
    assign head_inc = XW'(r_head) + XW'(1);

    // inner loop runs j over (i, tail); outer loop i over [head, tail-1)
    assign j_inc  = r_j + CW'(1);
    assign j_more = ({1'b0, r_j} + (CW+1)'(1)) < {1'b0, r_tail};
    assign i_more = ({1'b0, r_i} + (CW+1)'(2)) < {1'b0, r_tail};

    ustq_slot_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_i       = r_i;
        n_j       = r_j;
        n_ei      = r_ei;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_ticket  = r_ticket;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_tail[IW-1:0];
        ram_wdata = in_entry;
        ram_raddr = r_head[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_op)
                        OP_ENQ: begin
                            n_strobe = 1'b1;
                            n_out    = '0;
                            if (full) begin
                                n_status = ST_FULL;
                                n_ticket = '0;
                            end else begin
                                ram_we   = 1'b1;
                                n_status = ST_ENQUEUED;
                                n_ticket = tail_inc[TICKET_W-1:0];
                                n_tail   = r_tail + CW'(1);
                            end
                        end
                        OP_SORT: begin
                            if (few) begin
                                n_strobe = 1'b1;
                                n_status = ST_DONE;
                                n_ticket = '0;
                                n_out    = '0;
                            end else begin
                                n_i     = r_head;
                                n_state = S_SORT_RD_I;
                            end
                        end
                        OP_DEQ: begin
                            if (empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                                n_ticket = '0;
                                n_out    = '0;
                            end else begin
                                // head read issued on this edge
                                n_state = S_DEQ;
                            end
                        end
                        default: begin
                            // unused op: dropped
                        end
                    endcase
                end
            end
            S_SORT_RD_I: begin
                ram_raddr = r_i[IW-1:0];
                n_j       = r_i + CW'(1);
                n_state   = S_SORT_LD_I;
            end
            S_SORT_LD_I: begin
                n_ei      = ram_rdata;
                ram_raddr = r_j[IW-1:0];
                n_state   = S_SORT_J;
            end
            S_SORT_J: begin
                // compare/exchange: slot j takes the old winner
                if (r_ei.urgency < ram_rdata.urgency) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_j[IW-1:0];
                    ram_wdata = r_ei;
                    n_ei      = ram_rdata;
                end
                ram_raddr = j_inc[IW-1:0];
                if (j_more) begin
                    n_j = j_inc;
                end else begin
                    n_state = S_SORT_WB_I;
                end
            end
            S_SORT_WB_I: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[IW-1:0];
                ram_wdata = r_ei;
                if (i_more) begin
                    n_i     = r_i + CW'(1);
                    n_state = S_SORT_RD_I;
                end else begin
                    n_strobe = 1'b1;
                    n_status = ST_DONE;
                    n_ticket = '0;
                    n_out    = '0;
                    n_state  = S_IDLE;
                end
            end
            S_DEQ: begin
                n_strobe = 1'b1;
                n_status = ST_DONE;
                n_ticket = head_inc[TICKET_W-1:0];
                n_out    = ram_rdata;
                n_head   = r_head + CW'(1);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_cap    <= CAP_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
        r_i      <= n_i;
        r_j      <= n_j;
        r_ei     <= n_ei;
        r_status <= n_status;
        r_ticket <= n_ticket;
        r_out    <= n_out;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_ticket        = r_ticket;
    assign o_out_urgency   = r_out.urgency;
    assign o_out_age       = r_out.age;
    assign o_out_sex       = r_out.sex;
    assign o_out_insurance = r_out.insurance;
    assign o_out_tag       = r_out.tag;

endmodule

`default_nettype wire

### hw/rtl/ustq_checker.sv
// ----------------------------------------------------------------------------
// ustq_checker
// Port-level checks for the ticket queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ustq_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          o_strobe,
    input  wire logic [1:0]                    o_status,
    input  wire logic [ustq_pkg::TICKET_W-1:0] o_ticket,
    input  wire logic [2:0]                    o_out_urgency,
    input  wire logic [7:0]                    o_out_age,
    input  wire logic [1:0]                    o_out_sex,
    input  wire logic [1:0]                    o_out_insurance,
    input  wire logic [15:0]                   o_out_tag
);
    import ustq_pkg::*;

    logic out_zero;
    assign out_zero = (o_out_urgency == '0) && (o_out_age == '0) && (o_out_sex == '0)
                   && (o_out_insurance == '0) && (o_out_tag == '0);

    // a result beat follows an accepted command or ends a busy stretch
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(start && !busy) || $past(busy)))
        else $error("result beat without a command");

    // an enqueue beat always carries a slot ticket and no entry
    a_enq_ticket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_ENQUEUED) |-> (o_ticket != '0) && out_zero)
        else $error("enqueue beat with bad ticket or payload");

    // full and empty beats carry nothing
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_FULL || o_status == ST_EMPTY))
            |-> (o_ticket == '0) && out_zero)
        else $error("reject beat with nonzero fields");

    // a sort beat (done without ticket) carries no entry
    a_sort_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_DONE && o_ticket == '0) |-> out_zero)
        else $error("sort beat with payload");

endmodule

bind urgency_sorted_ticket_queue_unit ustq_checker u_ustq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_status        (o_status),
    .o_ticket        (o_ticket),
    .o_out_urgency   (o_out_urgency),
    .o_out_age       (o_out_age),
    .o_out_sex       (o_out_sex),
    .o_out_insurance (o_out_insurance),
    .o_out_tag       (o_out_tag)
);

`default_nettype wire
